/* sv/ddds_pkg.sv */
// Shared types and constants for the decimal digit display scanner.
// Used by the digit cell, the conversion chain and the top level.
`timescale 1ns / 1ps

package ddds_pkg;

	localparam int DIGIT_COUNT_DEF = 8;
	localparam int VALUE_W = 32;
	localparam int CODE_W = 5;
	localparam int BCD_W = 4;
	localparam logic [CODE_W-1:0] BLANK_CODE = 5'd17;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_WR_LO  = 2'd1,
		CMD_WR_HI  = 2'd2,
		CMD_WR_ALL = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_CONV = 1'b1
	} state_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} conv_status_t;

endpackage

/* sv/decimal_digit_display_scanner_top.sv */
// Top level of the decimal digit display scanner: command decode, digit store and scan.
// Depends on ddds_pkg and ddds_chain.
`timescale 1ns / 1ps

// Each input item carries a command in s_axis_tuser and a binary number in s_axis_tdata.
// A scan tick produces one output item holding the current position and its digit code,
// then advances the position, wrapping after the last digit. A write produces no item.
// A write converts its number serially, one bit per cycle through the row of digit
// cells, and stores the digits with leading-zero blanking; digit 0 always shows.
// A write occupies the block while it is accepted, for the 32 shift steps of the
// cell row, and while the store is updated; no further item is accepted meanwhile.
// A scan tick's item appears on the output in the next cycle, held in a register;
// ticks may follow one another in consecutive cycles while the output is taken.
// The output item is held in a register; while the receiver stalls it stays put and
// no new input item is accepted until the register is free or being emptied.
// Reset sets every stored digit to blank code 17 and the scan position to zero.

module decimal_digit_display_scanner_top #(
	parameter int DIGIT_COUNT = ddds_pkg::DIGIT_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,  // number[31:0]
	input  logic [1:0]                   s_axis_tuser,  // cmd[1:0]
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [7:0]                   m_axis_tdata   // digit_code, digit_position
);

	localparam int POS_W = $clog2(DIGIT_COUNT);
	localparam int HALF = DIGIT_COUNT / 2;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

	ddds_pkg::state_t state_q, state_d;
	ddds_pkg::cmd_t   in_cmd;
	ddds_pkg::cmd_t   wr_cmd_q;

	logic                                           in_acc;
	logic                                           tick_acc;
	logic                                           wr_acc;
	logic [DIGIT_COUNT-1:0][ddds_pkg::BCD_W-1:0]    digits;
	ddds_pkg::conv_status_t                         status;
	logic [ddds_pkg::VALUE_W-1:0]                   load_value;
	logic [DIGIT_COUNT-1:0]                         any_nz;
	logic [DIGIT_COUNT-1:0][ddds_pkg::CODE_W-1:0]   conv_code;
	logic [DIGIT_COUNT-1:0]                         wr_en;
	logic [DIGIT_COUNT-1:0][ddds_pkg::CODE_W-1:0]   wr_val;
	logic [DIGIT_COUNT-1:0][ddds_pkg::CODE_W-1:0]   store_q;
	logic [POS_W-1:0]                               scan_q;
	logic                                           out_valid_q;
	logic [POS_W-1:0]                               out_pos_q;
	logic [ddds_pkg::CODE_W-1:0]                    out_code_q;

	assign in_cmd        = ddds_pkg::cmd_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ddds_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign tick_acc      = in_acc && (in_cmd == ddds_pkg::CMD_TICK);
	assign wr_acc        = in_acc && (in_cmd != ddds_pkg::CMD_TICK);

	always_comb begin
		if (in_cmd == ddds_pkg::CMD_WR_ALL) begin
			load_value = s_axis_tdata;
		end else begin
			load_value = {16'd0, s_axis_tdata[15:0]};
		end
	end

	ddds_chain #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (wr_acc),
		.value  (load_value),
		.digits (digits),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ddds_pkg::ST_IDLE: begin
				if (wr_acc) begin
					state_d = ddds_pkg::ST_CONV;
				end
			end
			ddds_pkg::ST_CONV: begin
				if (status.done) begin
					state_d = ddds_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ddds_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_acc) begin
			wr_cmd_q <= in_cmd;
		end
	end

	// A digit other than digit 0 is blanked once it and every higher digit, including any dropped ones, is zero.
	always_comb begin
		any_nz[DIGIT_COUNT-1] = (digits[DIGIT_COUNT-1] != '0);
		for (int i = DIGIT_COUNT - 2; i >= 0; i--) begin
			any_nz[i] = any_nz[i+1] || (digits[i] != '0);
		end
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (i == 0 || status.ovf || any_nz[i]) begin
				conv_code[i] = {1'b0, digits[i]};
			end else begin
				conv_code[i] = ddds_pkg::BLANK_CODE;
			end
		end
	end

	always_comb begin
		for (int p = 0; p < DIGIT_COUNT; p++) begin
			wr_en[p]  = 1'b0;
			wr_val[p] = conv_code[p % HALF];
			case (wr_cmd_q)
				ddds_pkg::CMD_WR_LO: begin
					wr_en[p] = status.done && (p < HALF);
				end
				ddds_pkg::CMD_WR_HI: begin
					wr_en[p] = status.done && (p >= HALF);
				end
				ddds_pkg::CMD_WR_ALL: begin
					wr_en[p]  = status.done;
					wr_val[p] = conv_code[p];
				end
				default: begin
					wr_en[p] = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < DIGIT_COUNT; p++) begin
				store_q[p] <= ddds_pkg::BLANK_CODE;
			end
		end else begin
			for (int p = 0; p < DIGIT_COUNT; p++) begin
				if (wr_en[p]) begin
					store_q[p] <= wr_val[p];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				scan_q      <= (scan_q == POS_LAST) ? '0 : scan_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			out_pos_q  <= scan_q;
			out_code_q <= store_q[scan_q];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_code_q, out_pos_q};

	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> state_q == ddds_pkg::ST_CONV)
		else $error("conversion finished outside a write");

	a_write_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		wr_acc |=> state_q == ddds_pkg::ST_CONV)
		else $error("write item did not start a conversion");

	a_tick_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> m_axis_tvalid)
		else $error("scan tick produced no output item");

	a_scan_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_acc |=> $stable(scan_q))
		else $error("scan position moved without a tick");

	a_no_store_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddds_pkg::ST_IDLE) |-> (wr_en == '0))
		else $error("digit store written while idle");

endmodule

/* sv/ddds_cell.sv */
// One decimal digit cell of the shift-and-add-three conversion chain.
// Depends on ddds_pkg for the digit width.
`timescale 1ns / 1ps

module ddds_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        shift,
	input  logic                        bit_in,
	output logic                        bit_out,
	output logic [ddds_pkg::BCD_W-1:0]  digit
);

	logic [ddds_pkg::BCD_W-1:0] digit_q;
	logic [ddds_pkg::BCD_W-1:0] adj;

	always_comb begin
		adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	end

	assign bit_out = adj[ddds_pkg::BCD_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (clear) begin
			digit_q <= '0;
		end else if (shift) begin
			digit_q <= {adj[ddds_pkg::BCD_W-2:0], bit_in};
		end
	end

endmodule

/* sv/ddds_chain.sv */
// Row of decimal digit cells fed most significant bit first from a shift register.
// Depends on ddds_pkg and ddds_cell; reports completion and decimal overflow.
`timescale 1ns / 1ps

module ddds_chain #(
	parameter int DIGIT_COUNT = ddds_pkg::DIGIT_COUNT_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          load,
	input  logic [ddds_pkg::VALUE_W-1:0]                  value,
	output logic [DIGIT_COUNT-1:0][ddds_pkg::BCD_W-1:0]   digits,
	output ddds_pkg::conv_status_t                        status
);

	localparam int CNT_W = $clog2(ddds_pkg::VALUE_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ddds_pkg::VALUE_W - 1);

	logic [ddds_pkg::VALUE_W-1:0] shreg_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic                         ovf_q;
	logic [DIGIT_COUNT:0]         carry;

	assign carry[0] = shreg_q[ddds_pkg::VALUE_W-1];

	for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
		ddds_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clear   (load),
			.shift   (busy_q),
			.bit_in  (carry[g]),
			.bit_out (carry[g+1]),
			.digit   (digits[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shreg_q <= '0;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				shreg_q <= value;
				cnt_q   <= '0;
				busy_q  <= 1'b1;
				ovf_q   <= 1'b0;
			end else if (busy_q) begin
				shreg_q <= {shreg_q[ddds_pkg::VALUE_W-2:0], 1'b0};
				cnt_q   <= cnt_q + 1'b1;
				if (carry[DIGIT_COUNT]) begin
					ovf_q <= 1'b1;
				end
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status = '{done: done_q, ovf: ovf_q};

endmodule
